>>> hdl/aiec_pkg.sv
package aiec_pkg;

	// Storage geometry
	localparam int CAPACITY   = 256;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(CAPACITY);
	localparam int LEN_W      = $clog2(CAPACITY + 1);

	// Fixed field widths of the item and result beats
	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 9;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	// Width that holds an index, a length and either plus one
	localparam int CMP_W = ((LEN_W > INDEX_W) ? LEN_W : INDEX_W) + 1;

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COUNT  = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic                capture;
		logic                rd_en;
		logic [ADDR_W-1:0]   rd_addr;
		logic                wr_shift;
		logic                wr_value;
		logic [ADDR_W-1:0]   wr_addr;
		logic                cmp_en;
		logic                len_inc;
		logic                len_dec;
		logic                load_res;
		logic [STATUS_W-1:0] res_status;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [LEN_W-1:0] length;
	} dp_status_t;

endpackage

>>> hdl/aiec_req_if.sv
interface aiec_req_if;

	logic                             valid;
	logic                             ready;
	logic [aiec_pkg::FUNC_W-1:0]      func;
	logic [aiec_pkg::INDEX_W-1:0]     index;
	logic signed [aiec_pkg::VALUE_W-1:0] value;

	modport source (output valid, output func, output index, output value, input ready);
	modport sink (input valid, input func, input index, input value, output ready);

endinterface

>>> hdl/aiec_rsp_if.sv
interface aiec_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [aiec_pkg::STATUS_W-1:0] status;
	logic [aiec_pkg::COUNT_W-1:0]  match_count;

	modport source (output valid, output status, output match_count, input ready);
	modport sink (input valid, input status, input match_count, output ready);

endinterface

>>> hdl/aiec_ctrl.sv
module aiec_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [aiec_pkg::FUNC_W-1:0]     func,
	input  logic [aiec_pkg::INDEX_W-1:0]    index,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  aiec_pkg::dp_status_t            dp_status,
	output aiec_pkg::cmd_t                  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		SHIFT_UP,
		SHIFT_DN,
		SCAN,
		TAIL,
		FINISH
	} state_t;

	state_t                               state_q;
	logic [aiec_pkg::FUNC_W-1:0]          op_q;
	logic [aiec_pkg::LEN_W-1:0]           ptr_q;
	logic [aiec_pkg::LEN_W-1:0]           last_q;
	logic [aiec_pkg::STATUS_W-1:0]        res_st_q;
	logic                                 out_valid_q;
	logic                                 pend_s1;
	logic [aiec_pkg::ADDR_W-1:0]          wr_addr_s1;

	logic [aiec_pkg::CMP_W-1:0]           idx_w;
	logic [aiec_pkg::CMP_W-1:0]           len_w;
	logic [aiec_pkg::LEN_W-1:0]           ptr_up;
	logic [aiec_pkg::LEN_W-1:0]           ptr_dn;
	logic                                 accept;

	assign idx_w     = aiec_pkg::CMP_W'(index);
	assign len_w     = aiec_pkg::CMP_W'(dp_status.length);
	assign ptr_up    = ptr_q + 1'b1;
	assign ptr_dn    = ptr_q - 1'b1;
	assign req_ready = (state_q == IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	// Decode commands from the current state and the pending read
	always_comb begin
		cmd            = '0;
		cmd.capture    = accept;
		cmd.rd_addr    = ptr_q[aiec_pkg::ADDR_W-1:0];
		cmd.wr_addr    = wr_addr_s1;
		cmd.res_status = res_st_q;
		if (pend_s1) begin
			if (op_q == aiec_pkg::FUNC_COUNT) begin
				cmd.cmp_en = 1'b1;
			end else begin
				cmd.wr_shift = 1'b1;
			end
		end
		case (state_q)
			SHIFT_UP, SHIFT_DN, SCAN: begin
				cmd.rd_en = 1'b1;
			end
			TAIL: begin
				if (!pend_s1) begin
					case (op_q)
						aiec_pkg::FUNC_INSERT: begin
							cmd.wr_value = 1'b1;
							cmd.wr_addr  = last_q[aiec_pkg::ADDR_W-1:0];
							cmd.len_inc  = 1'b1;
						end
						aiec_pkg::FUNC_ERASE: begin
							cmd.len_dec = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			FINISH: begin
				cmd.load_res = !out_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	// Sequence one item: check, walk the array, finish, hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			op_q        <= aiec_pkg::FUNC_INSERT;
			ptr_q       <= '0;
			last_q      <= '0;
			res_st_q    <= aiec_pkg::STATUS_OK;
			pend_s1     <= 1'b0;
			wr_addr_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a read issued in a walk state is written or compared next cycle
			pend_s1 <= (state_q inside {SHIFT_UP, SHIFT_DN, SCAN});
			// raise the response beat on finish, drop it once taken
			if (state_q == FINISH && (!out_valid_q || rsp_ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (req_valid) begin
						op_q <= func;
						case (func)
							aiec_pkg::FUNC_INSERT: begin
								last_q <= aiec_pkg::LEN_W'(idx_w);
								ptr_q  <= dp_status.length - 1'b1;
								if (idx_w > len_w) begin
									res_st_q <= aiec_pkg::STATUS_RANGE;
									state_q  <= FINISH;
								end else if (len_w == aiec_pkg::CMP_W'(aiec_pkg::CAPACITY)) begin
									res_st_q <= aiec_pkg::STATUS_FULL;
									state_q  <= FINISH;
								end else if (idx_w == len_w) begin
									res_st_q <= aiec_pkg::STATUS_OK;
									state_q  <= TAIL;
								end else begin
									res_st_q <= aiec_pkg::STATUS_OK;
									state_q  <= SHIFT_UP;
								end
							end
							aiec_pkg::FUNC_ERASE: begin
								ptr_q  <= aiec_pkg::LEN_W'(idx_w + 1'b1);
								last_q <= dp_status.length - 1'b1;
								if (idx_w >= len_w) begin
									res_st_q <= aiec_pkg::STATUS_RANGE;
									state_q  <= FINISH;
								end else if (idx_w + 1'b1 == len_w) begin
									res_st_q <= aiec_pkg::STATUS_OK;
									state_q  <= TAIL;
								end else begin
									res_st_q <= aiec_pkg::STATUS_OK;
									state_q  <= SHIFT_DN;
								end
							end
							aiec_pkg::FUNC_COUNT: begin
								ptr_q    <= '0;
								last_q   <= dp_status.length - 1'b1;
								res_st_q <= aiec_pkg::STATUS_OK;
								if (len_w == '0) begin
									state_q <= FINISH;
								end else begin
									state_q <= SCAN;
								end
							end
							default: begin
								res_st_q <= aiec_pkg::STATUS_OK;
								state_q  <= FINISH;
							end
						endcase
					end
				end
				SHIFT_UP, SHIFT_DN, SCAN: begin
					// issue one read; its write or compare follows next cycle
					if (state_q == SHIFT_UP) begin
						wr_addr_s1 <= ptr_up[aiec_pkg::ADDR_W-1:0];
					end else begin
						wr_addr_s1 <= ptr_dn[aiec_pkg::ADDR_W-1:0];
					end
					if (ptr_q == last_q) begin
						state_q <= TAIL;
					end else if (state_q == SHIFT_UP) begin
						ptr_q <= ptr_dn;
					end else begin
						ptr_q <= ptr_up;
					end
				end
				TAIL: begin
					// wait for the last pending beat, then finish the update
					if (!pend_s1) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (!out_valid_q || rsp_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/aiec_dpath.sv
module aiec_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aiec_pkg::cmd_t                      cmd,
	input  logic signed [aiec_pkg::VALUE_W-1:0] value,
	output aiec_pkg::dp_status_t                dp_status,
	output logic [aiec_pkg::STATUS_W-1:0]       status,
	output logic [aiec_pkg::COUNT_W-1:0]        match_count
);

	logic [aiec_pkg::DATA_WIDTH-1:0] mem_q [aiec_pkg::CAPACITY];
	logic [aiec_pkg::DATA_WIDTH-1:0] rdata_q;
	logic [aiec_pkg::DATA_WIDTH-1:0] value_q;
	logic [aiec_pkg::DATA_WIDTH-1:0] wdata;
	logic [aiec_pkg::LEN_W-1:0]      length_q;
	logic [aiec_pkg::COUNT_W-1:0]    count_q;
	logic [aiec_pkg::STATUS_W-1:0]   status_q;
	logic [aiec_pkg::COUNT_W-1:0]    match_q;

	assign wdata            = cmd.wr_shift ? rdata_q : value_q;
	assign dp_status.length = length_q;
	assign status           = status_q;
	assign match_count      = match_q;

	// Entry store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_shift || cmd.wr_value) begin
			mem_q[cmd.wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[cmd.rd_addr];
		end
	end

	// Hold the item word, accumulate matches, latch the result beat
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			value_q <= value[aiec_pkg::DATA_WIDTH-1:0];
			count_q <= '0;
		end else if (cmd.cmp_en && (rdata_q == value_q)) begin
			count_q <= count_q + 1'b1;
		end
		if (cmd.load_res) begin
			status_q <= cmd.res_status;
			match_q  <= count_q;
		end
	end

	// Track the current length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (cmd.len_inc) begin
			length_q <= length_q + 1'b1;
		end else if (cmd.len_dec) begin
			length_q <= length_q - 1'b1;
		end
	end

endmodule

>>> hdl/array_insert_erase_count_core.sv
// Ordered array of up to 256 signed 32-bit words with a current length; each
// request beat inserts a word at a position, erases the entry at a position, or
// counts the entries equal to a word, and gives exactly one response beat with a
// status (ok, index out of range, array full) and the match count. A bad index
// or a full array leaves the contents untouched; an unused operation code only
// answers ok. Items are handled one at a time: the entries live in a
// single-port-write memory that is walked one entry per cycle. A finished
// response waits in its output register while the next request is already
// taken. No clearing pass runs after reset: entries are only read below the
// current length.
module array_insert_erase_count_core (
	input  logic        clk,
	input  logic        arst_n,
	aiec_req_if.sink    req,
	aiec_rsp_if.source  rsp
);

	aiec_pkg::cmd_t       cmd;
	aiec_pkg::dp_status_t dp_status;

	aiec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.func      (req.func),
		.index     (req.index),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.dp_status (dp_status),
		.cmd       (cmd)
	);

	aiec_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (req.value),
		.dp_status   (dp_status),
		.status      (rsp.status),
		.match_count (rsp.match_count)
	);

endmodule
